// File: rtl/core/stp_pkg.sv
// Shared constants, codes and types of the stepper trapezoid positioner.
package stp_pkg;

	// Widths of position and delay arithmetic.
	localparam int POS_W = 32;
	localparam int DLY_W = 16;
	localparam int ACC_W = 16;
	localparam int JOG_W = 16;
	localparam int WAIT_W = DLY_W + 1;
	localparam int PROD_W = DLY_W + ACC_W;
	localparam int CNT_W = $clog2(DLY_W + 1);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W = (DLY_W > 16) ? DLY_W : 16;

	// Register reset values.
	localparam logic [ACC_W-1:0] ACCEL_RST = ACC_W'(200);
	localparam logic [DLY_W-1:0] START_RST = DLY_W'(1000);
	localparam logic [DLY_W-1:0] MIN_RST = DLY_W'(200);
	localparam logic [JOG_W-1:0] JOG_RST = JOG_W'(100);

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_JOG = 2'd3;

	// Item kinds.
	localparam logic [2:0] KIND_TICK = 3'd0;
	localparam logic [2:0] KIND_GO_OPEN = 3'd1;
	localparam logic [2:0] KIND_GO_CLOSE = 3'd2;
	localparam logic [2:0] KIND_JOG = 3'd3;
	localparam logic [2:0] KIND_SAVE_OPEN = 3'd4;
	localparam logic [2:0] KIND_SAVE_CLOSE = 3'd5;

	// Status codes.
	localparam logic [2:0] ST_NONE = 3'd0;
	localparam logic [2:0] ST_STARTED = 3'd1;
	localparam logic [2:0] ST_NOT_CAL = 3'd2;
	localparam logic [2:0] ST_BUSY = 3'd3;
	localparam logic [2:0] ST_AT_TARGET = 3'd4;
	localparam logic [2:0] ST_SAVED = 3'd5;

	// Input word.
	typedef struct packed {
		logic [2:0] kind;
		logic       jog_toward_open;
	} in_t;

	// Output word.
	typedef struct packed {
		logic                    step_level;
		logic                    dir_level;
		logic                    busy_res;
		logic signed [POS_W-1:0] position;
		logic                    limits_valid;
		logic [2:0]              status;
	} out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic prep;
		logic div_start;
		logic commit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;
		logic div_busy;
	} dp_sts_t;

endpackage

// File: rtl/core/stepper_trapezoid_positioner.sv
// Top level of the stepper trapezoid positioner.
//
// The input channel (in_valid/in_ready/in_data) carries one word per microsecond
// tick or command: go open, go close, jog, save open, save close. For every
// accepted word exactly one output word (out_valid/out_ready/out_data) follows,
// giving the step and direction pin levels, the busy flag, the position, whether
// the limits are calibrated and a command status.
// Each word passes the controller states idle, prep, mul and commit; a tick
// that waits for a step inside the acceleration or deceleration ramp also passes
// a divide state, as the ramp delay needs a restoring divide, one quotient bit
// per cycle. A new word is accepted only once the previous one has committed.
// The output word sits in its own register; while the receiver stalls, the next
// word is still accepted and processed, and it waits at commit until the output
// register is free.
// Registers are written on the cfg channel (cfg_valid/cfg_ready, always ready);
// the user must write them only while no word is in flight; the block does not
// enforce this. Reset restores the register defaults and clears the position,
// both saved positions and any move.
module stepper_trapezoid_positioner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  stp_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output stp_pkg::out_t                 out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [stp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [stp_pkg::CFG_W-1:0]     cfg_data
);

	stp_pkg::dp_cmd_t cmd;
	stp_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	stp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	stp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

	// The step pin is never high without a move in progress.
	a_step_needs_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.step_level && !out_data.busy_res))
		else $error("step pin high while idle");

	// A started move reports busy.
	a_started_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == stp_pkg::ST_STARTED) |-> out_data.busy_res)
		else $error("move started but not busy");

	// A refusal for missing calibration means the limits are equal.
	a_not_cal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == stp_pkg::ST_NOT_CAL) |-> !out_data.limits_valid)
		else $error("not calibrated reported with valid limits");

	// No new word is taken while the divider still runs.
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !sts.div_busy)
		else $error("input ready during divide");

endmodule

// File: rtl/core/stp_div.sv
// Restoring divider, one quotient bit per cycle, for the ramp delay.
module stp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [stp_pkg::PROD_W-1:0]  num,
	input  logic [stp_pkg::ACC_W-1:0]   den,
	output logic                        busy,
	output logic [stp_pkg::DLY_W-1:0]   quo
);

	logic [stp_pkg::ACC_W-1:0] rem_q;
	logic [stp_pkg::DLY_W-1:0] quo_q;
	logic [stp_pkg::CNT_W-1:0] cnt_q;
	logic [stp_pkg::ACC_W:0]   trial;
	logic [stp_pkg::ACC_W:0]   diff;
	logic                      ge;

	// Shift in the next numerator bit and try a subtract.
	assign trial = {rem_q, quo_q[stp_pkg::DLY_W-1]};
	assign diff = trial - {1'b0, den};
	assign ge = (trial >= {1'b0, den});

	// Iteration counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= stp_pkg::CNT_W'(stp_pkg::DLY_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// The upper numerator half is below the divisor, so the quotient fits DLY_W bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[stp_pkg::PROD_W-1:stp_pkg::DLY_W];
			quo_q <= num[stp_pkg::DLY_W-1:0];
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[stp_pkg::ACC_W-1:0] : trial[stp_pkg::ACC_W-1:0];
			quo_q <= {quo_q[stp_pkg::DLY_W-2:0], ge};
		end
	end

	assign busy = (cnt_q != '0);
	assign quo = quo_q;

endmodule

// File: rtl/core/stp_dp.sv
// Datapath: registers, move state, ramp delay arithmetic and the output word.
module stp_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stp_pkg::in_t                  in_data,
	input  logic                          cfg_we,
	input  logic [stp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [stp_pkg::CFG_W-1:0]     cfg_data,
	input  stp_pkg::dp_cmd_t              cmd,
	output stp_pkg::dp_sts_t              sts,
	output stp_pkg::out_t                 out_data
);

	// Configuration registers.
	logic [stp_pkg::ACC_W-1:0] accel_q;
	logic [stp_pkg::DLY_W-1:0] start_q;
	logic [stp_pkg::DLY_W-1:0] min_q;
	logic [stp_pkg::JOG_W-1:0] jog_q;

	// Motion state.
	logic [stp_pkg::POS_W-1:0]  cur_pos_q, open_pos_q, close_pos_q;
	logic [stp_pkg::POS_W-1:0]  steps_left_q, steps_done_q;
	logic [stp_pkg::WAIT_W-1:0] wait_q;
	logic [stp_pkg::DLY_W-1:0]  high_q;
	logic                       moving_q, dir_q, pulse_q;

	// Next values.
	logic [stp_pkg::POS_W-1:0]  cur_pos_d, open_pos_d, close_pos_d;
	logic [stp_pkg::POS_W-1:0]  steps_left_d, steps_done_d;
	logic [stp_pkg::WAIT_W-1:0] wait_d;
	logic [stp_pkg::DLY_W-1:0]  high_d;
	logic                       moving_d, dir_d, pulse_d;
	logic [2:0]                 status_d;

	// Item and prep stage.
	stp_pkg::in_t               item_q;
	logic [stp_pkg::DLY_W-1:0]  lo_s1, span_s1;
	logic [stp_pkg::ACC_W-1:0]  phase_s1;
	logic                       need_div_s1;

	// Combinational helpers.
	logic [stp_pkg::DLY_W-1:0]  lo;
	logic [stp_pkg::POS_W-1:0]  left_m1, phase_full;
	logic                       need_div_c;
	logic [stp_pkg::PROD_W-1:0] prod;
	logic [stp_pkg::DLY_W-1:0]  quo;
	logic                       div_busy;
	logic [stp_pkg::DLY_W-1:0]  d_raw, d_half;
	logic [stp_pkg::WAIT_W-1:0] two_d, wait_inc;
	logic [stp_pkg::DLY_W-1:0]  high_dec;
	logic [stp_pkg::POS_W-1:0]  target, diff, mag;
	logic                       neg;
	stp_pkg::out_t              out_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q <= stp_pkg::ACCEL_RST;
			start_q <= stp_pkg::START_RST;
			min_q <= stp_pkg::MIN_RST;
			jog_q <= stp_pkg::JOG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				stp_pkg::CFG_ACCEL: accel_q <= cfg_data[stp_pkg::ACC_W-1:0];
				stp_pkg::CFG_START: start_q <= cfg_data[stp_pkg::DLY_W-1:0];
				stp_pkg::CFG_MIN: min_q <= cfg_data[stp_pkg::DLY_W-1:0];
				stp_pkg::CFG_JOG: jog_q <= cfg_data[stp_pkg::JOG_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the accepted word.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_data;
		end
	end

	// Ramp phase: distance to the nearer end of the move.
	assign lo = (min_q > start_q) ? start_q : min_q;
	assign left_m1 = steps_left_q - 1'b1;
	assign phase_full = (steps_done_q < left_m1) ? steps_done_q : left_m1;
	assign need_div_c = (item_q.kind == stp_pkg::KIND_TICK) && moving_q && !pulse_q &&
		(phase_full < stp_pkg::POS_W'(accel_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_div_s1 <= 1'b0;
		end else if (cmd.prep) begin
			need_div_s1 <= need_div_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			lo_s1 <= lo;
			span_s1 <= start_q - lo;
			phase_s1 <= phase_full[stp_pkg::ACC_W-1:0];
		end
	end

	// Slope term, divided by the ramp length over the following cycles.
	assign prod = span_s1 * phase_s1;

	stp_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (prod),
		.den   (accel_q),
		.busy  (div_busy),
		.quo   (quo)
	);

	assign sts.need_div = need_div_s1;
	assign sts.div_busy = div_busy;

	// Half period; a zero delay counts as one tick.
	assign d_raw = need_div_s1 ? (start_q - quo) : lo_s1;
	assign d_half = (d_raw == '0) ? stp_pkg::DLY_W'(1) : d_raw;
	assign two_d = {d_half, 1'b0};
	assign wait_inc = (wait_q == '1) ? wait_q : (wait_q + 1'b1);
	assign high_dec = (high_q != '0) ? (high_q - 1'b1) : high_q;

	// Shorter way round to the saved target.
	assign target = (item_q.kind == stp_pkg::KIND_GO_OPEN) ? open_pos_q : close_pos_q;
	assign diff = target - cur_pos_q;
	assign neg = diff[stp_pkg::POS_W-1];
	assign mag = neg ? (-diff) : diff;

	// Next state for the item in hand.
	always_comb begin
		cur_pos_d = cur_pos_q;
		open_pos_d = open_pos_q;
		close_pos_d = close_pos_q;
		steps_left_d = steps_left_q;
		steps_done_d = steps_done_q;
		wait_d = wait_q;
		high_d = high_q;
		moving_d = moving_q;
		dir_d = dir_q;
		pulse_d = pulse_q;
		status_d = stp_pkg::ST_NONE;
		case (item_q.kind)
			stp_pkg::KIND_TICK: begin
				if (moving_q && pulse_q) begin
					high_d = high_dec;
					if (high_dec == '0) begin
						pulse_d = 1'b0;
						wait_d = '0;
						cur_pos_d = dir_q ? (cur_pos_q + 1'b1) : (cur_pos_q - 1'b1);
						steps_done_d = steps_done_q + 1'b1;
						steps_left_d = left_m1;
						if (left_m1 == '0) begin
							moving_d = 1'b0;
						end
					end
				end else if (moving_q) begin
					wait_d = wait_inc;
					if (wait_inc >= two_d) begin
						pulse_d = 1'b1;
						high_d = d_half;
						wait_d = '0;
					end
				end
			end
			stp_pkg::KIND_GO_OPEN, stp_pkg::KIND_GO_CLOSE: begin
				if (open_pos_q == close_pos_q) begin
					status_d = stp_pkg::ST_NOT_CAL;
				end else if (moving_q) begin
					status_d = stp_pkg::ST_BUSY;
				end else if (diff == '0) begin
					status_d = stp_pkg::ST_AT_TARGET;
				end else begin
					moving_d = 1'b1;
					steps_left_d = mag;
					steps_done_d = '0;
					dir_d = !neg;
					wait_d = '0;
					high_d = '0;
					pulse_d = 1'b0;
					status_d = stp_pkg::ST_STARTED;
				end
			end
			stp_pkg::KIND_JOG: begin
				if (moving_q) begin
					status_d = stp_pkg::ST_BUSY;
				end else if (jog_q != '0) begin
					moving_d = 1'b1;
					steps_left_d = stp_pkg::POS_W'(jog_q);
					steps_done_d = '0;
					dir_d = item_q.jog_toward_open;
					wait_d = '0;
					high_d = '0;
					pulse_d = 1'b0;
					status_d = stp_pkg::ST_STARTED;
				end
			end
			stp_pkg::KIND_SAVE_OPEN: begin
				open_pos_d = cur_pos_q;
				status_d = stp_pkg::ST_SAVED;
			end
			stp_pkg::KIND_SAVE_CLOSE: begin
				close_pos_d = cur_pos_q;
				status_d = stp_pkg::ST_SAVED;
			end
			default: ;
		endcase
	end

	// Motion state update at commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pos_q <= '0;
			open_pos_q <= '0;
			close_pos_q <= '0;
			steps_left_q <= '0;
			steps_done_q <= '0;
			wait_q <= '0;
			high_q <= '0;
			moving_q <= 1'b0;
			dir_q <= 1'b0;
			pulse_q <= 1'b0;
		end else if (cmd.commit) begin
			cur_pos_q <= cur_pos_d;
			open_pos_q <= open_pos_d;
			close_pos_q <= close_pos_d;
			steps_left_q <= steps_left_d;
			steps_done_q <= steps_done_d;
			wait_q <= wait_d;
			high_q <= high_d;
			moving_q <= moving_d;
			dir_q <= dir_d;
			pulse_q <= pulse_d;
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.step_level <= pulse_d;
			out_q.dir_level <= dir_d;
			out_q.busy_res <= moving_d;
			out_q.position <= $signed(cur_pos_d);
			out_q.limits_valid <= (open_pos_d != close_pos_d);
			out_q.status <= status_d;
		end
	end

	assign out_data = out_q;

endmodule

// File: rtl/core/stp_ctrl.sv
// Controller state machine: sequences accept, prep, divide and commit of one word.
module stp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output stp_pkg::dp_cmd_t cmd,
	input  stp_pkg::dp_sts_t sts
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_PREP   = 5'b00010,
		S_MUL    = 5'b00100,
		S_DIV    = 5'b01000,
		S_COMMIT = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	// The output register can take a new word once the old one leaves.
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				if (sts.need_div) begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_DIV: begin
				if (!sts.div_busy) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: dv/tb_stepper_trapezoid_positioner.sv
// Testbench for the stepper trapezoid positioner: directed table, then predicted random words.
`timescale 1ns / 1ps

module tb_stepper_trapezoid_positioner;
	import stp_pkg::*;

	localparam int HALF_CLK = 5;
	localparam int NUM_PHASES = 8;

	// Kinds the block ignores.
	localparam logic [2:0] KIND_SPARE_A = 3'd6;
	localparam logic [2:0] KIND_SPARE_B = 3'd7;

	localparam out_t NO_GOLDEN = '0;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_t                  in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	stepper_trapezoid_positioner dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #HALF_CLK clk = ~clk;

	// Predicted copy of the registers and of the axis state.
	logic [ACC_W-1:0]  ramp_len = ACCEL_RST;
	logic [DLY_W-1:0]  slow_half = START_RST;
	logic [DLY_W-1:0]  fast_half = MIN_RST;
	logic [JOG_W-1:0]  jog_len = JOG_RST;
	logic [POS_W-1:0]  axis_pos = '0;
	logic [POS_W-1:0]  open_pos = '0;
	logic [POS_W-1:0]  close_pos = '0;
	logic [POS_W-1:0]  steps_to_go = '0;
	logic [POS_W-1:0]  steps_taken = '0;
	logic [WAIT_W-1:0] gap_ticks = '0;
	logic [DLY_W-1:0]  pulse_ticks = '0;
	logic              in_motion = 1'b0;
	logic              heading_up = 1'b0;
	logic              pin_high = 1'b0;

	out_t pin_words_due[$];
	int   fail_count = 0;
	int   hold_left = 0;
	bit   tx_gaps = 1'b1;
	bit   rx_gaps = 1'b1;

	// Directed rows: a golden word is given only where it is obvious.
	typedef struct packed {
		in_t  word;
		bit   typed;
		out_t golden;
	} opening_row_t;

	opening_row_t opening_rows [26] = '{
		// Idle after reset; unknown kinds change nothing.
		'{'{KIND_TICK, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 32'sd0, 1'b0, ST_NONE}},
		'{'{KIND_SPARE_A, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 32'sd0, 1'b0, ST_NONE}},
		'{'{KIND_SPARE_B, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 32'sd0, 1'b0, ST_NONE}},
		// Moves to saved positions are refused while both are equal.
		'{'{KIND_GO_OPEN, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 32'sd0, 1'b0, ST_NOT_CAL}},
		'{'{KIND_GO_CLOSE, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 32'sd0, 1'b0, ST_NOT_CAL}},
		// A jog needs no calibration; calibration is checked before busy.
		'{'{KIND_JOG, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, 32'sd0, 1'b0, ST_STARTED}},
		'{'{KIND_JOG, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1, 32'sd0, 1'b0, ST_BUSY}},
		'{'{KIND_GO_CLOSE, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, 32'sd0, 1'b0, ST_NOT_CAL}},
		// Saving while moving stores the position of that moment.
		'{'{KIND_SAVE_OPEN, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, 32'sd0, 1'b0, ST_SAVED}},
		// Two steps down at the shortest delay.
		'{'{KIND_TICK, 1'b0}, 1'b0, NO_GOLDEN},
		'{'{KIND_TICK, 1'b0}, 1'b0, NO_GOLDEN},
		'{'{KIND_TICK, 1'b0}, 1'b0, NO_GOLDEN},
		'{'{KIND_TICK, 1'b0}, 1'b0, NO_GOLDEN},
		'{'{KIND_TICK, 1'b0}, 1'b0, NO_GOLDEN},
		'{'{KIND_TICK, 1'b0}, 1'b0, NO_GOLDEN},
		// Calibrate, then go to where the axis already sits.
		'{'{KIND_SAVE_CLOSE, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, -32'sd2, 1'b1, ST_SAVED}},
		'{'{KIND_GO_CLOSE, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, -32'sd2, 1'b1, ST_AT_TARGET}},
		'{'{KIND_GO_OPEN, 1'b0}, 1'b1, '{1'b0, 1'b1, 1'b1, -32'sd2, 1'b1, ST_STARTED}},
		'{'{KIND_GO_CLOSE, 1'b0}, 1'b1, '{1'b0, 1'b1, 1'b1, -32'sd2, 1'b1, ST_BUSY}},
		'{'{KIND_TICK, 1'b1}, 1'b0, NO_GOLDEN},
		'{'{KIND_TICK, 1'b1}, 1'b0, NO_GOLDEN},
		'{'{KIND_TICK, 1'b1}, 1'b0, NO_GOLDEN},
		'{'{KIND_TICK, 1'b1}, 1'b0, NO_GOLDEN},
		'{'{KIND_TICK, 1'b1}, 1'b0, NO_GOLDEN},
		'{'{KIND_TICK, 1'b1}, 1'b0, NO_GOLDEN},
		'{'{KIND_GO_OPEN, 1'b1}, 1'b1, '{1'b0, 1'b1, 1'b0, 32'sd0, 1'b1, ST_AT_TARGET}}
	};

	// Register settings per random phase: accel_steps, start_delay, min_delay, jog_steps.
	int unsigned phase_cfg [NUM_PHASES][4] = '{
		'{4, 6, 2, 7},
		'{0, 5, 2, 4},
		'{3, 2, 65535, 3},
		'{1, 0, 0, 5},
		'{2, 3, 1, 0},
		'{65535, 4, 1, 9},
		'{10, 12, 3, 20},
		'{65535, 65535, 65535, 65535}
	};
	int phase_len [NUM_PHASES] = '{260, 260, 260, 260, 240, 260, 360, 50};

	// Half period of the next step, following the trapezoid ramp.
	function automatic longint unsigned ramp_half_period();
		longint unsigned floor_d, phase, d;
		floor_d = (fast_half > slow_half) ? slow_half : fast_half;
		phase = steps_to_go - 1;
		if (steps_taken < phase)
			phase = steps_taken;
		if (phase < ramp_len)
			d = slow_half - ((slow_half - floor_d) * phase) / ramp_len;
		else
			d = floor_d;
		if (d == 0)
			d = 1;
		return d;
	endfunction

	function automatic void begin_move(input logic [POS_W-1:0] steps, input logic up);
		if (steps == 0)
			return;
		in_motion = 1'b1;
		steps_to_go = steps;
		steps_taken = '0;
		heading_up = up;
		gap_ticks = '0;
		pulse_ticks = '0;
		pin_high = 1'b0;
	endfunction

	// One microsecond tick: count down the pulse, or wait for the next step.
	function automatic void advance_one_tick();
		longint unsigned d;
		if (!in_motion)
			return;
		if (pin_high) begin
			if (pulse_ticks > 0)
				pulse_ticks--;
			if (pulse_ticks == 0) begin
				pin_high = 1'b0;
				gap_ticks = '0;
				axis_pos = heading_up ? axis_pos + 1 : axis_pos - 1;
				steps_taken++;
				steps_to_go--;
				if (steps_to_go == 0)
					in_motion = 1'b0;
			end
			return;
		end
		if (gap_ticks != '1)
			gap_ticks++;
		d = ramp_half_period();
		if (gap_ticks >= 2 * d) begin
			pin_high = 1'b1;
			pulse_ticks = d[DLY_W-1:0];
			gap_ticks = '0;
		end
	endfunction

	// Move to a saved position the shorter way round, if allowed.
	function automatic logic [2:0] head_to(input logic [POS_W-1:0] target);
		logic [POS_W-1:0] diff;
		diff = target - axis_pos;
		if (open_pos == close_pos)
			return ST_NOT_CAL;
		if (in_motion)
			return ST_BUSY;
		if (diff == 0)
			return ST_AT_TARGET;
		if (diff[POS_W-1])
			begin_move(-diff, 1'b0);
		else
			begin_move(diff, 1'b1);
		return ST_STARTED;
	endfunction

	// Apply one input word to the predicted state and form the output word.
	function automatic out_t positioner_step(input in_t w);
		logic [2:0] verdict;
		out_t       r;
		verdict = ST_NONE;
		case (w.kind)
			KIND_TICK: advance_one_tick();
			KIND_GO_OPEN: verdict = head_to(open_pos);
			KIND_GO_CLOSE: verdict = head_to(close_pos);
			KIND_JOG: begin
				if (in_motion) begin
					verdict = ST_BUSY;
				end else if (jog_len != 0) begin
					begin_move(jog_len, w.jog_toward_open);
					verdict = ST_STARTED;
				end
			end
			KIND_SAVE_OPEN: begin
				open_pos = axis_pos;
				verdict = ST_SAVED;
			end
			KIND_SAVE_CLOSE: begin
				close_pos = axis_pos;
				verdict = ST_SAVED;
			end
			default: ;
		endcase
		r.step_level = pin_high;
		r.dir_level = heading_up;
		r.busy_res = in_motion;
		r.position = axis_pos;
		r.limits_valid = (open_pos != close_pos);
		r.status = verdict;
		return r;
	endfunction

	function automatic void latch_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		case (idx)
			CFG_ACCEL: ramp_len = val[ACC_W-1:0];
			CFG_START: slow_half = val[DLY_W-1:0];
			CFG_MIN: fast_half = val[DLY_W-1:0];
			CFG_JOG: jog_len = val[JOG_W-1:0];
			default: ;
		endcase
	endfunction

	task automatic note_fault(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// Compare each accepted output word with the oldest prediction.
	always @(posedge clk) begin
		out_t want;
		if (out_valid && out_ready) begin
			if (pin_words_due.size() == 0) begin
				note_fault("word with nothing due", out_data, '0);
			end else begin
				want = pin_words_due.pop_front();
				if (out_data.step_level !== want.step_level)
					note_fault("step_level", out_data.step_level, want.step_level);
				if (out_data.dir_level !== want.dir_level)
					note_fault("dir_level", out_data.dir_level, want.dir_level);
				if (out_data.busy_res !== want.busy_res)
					note_fault("busy_res", out_data.busy_res, want.busy_res);
				if (out_data.position !== want.position)
					note_fault("position", out_data.position, want.position);
				if (out_data.limits_valid !== want.limits_valid)
					note_fault("limits_valid", out_data.limits_valid, want.limits_valid);
				if (out_data.status !== want.status)
					note_fault("status", out_data.status, want.status);
			end
		end
	end

	// Receiver: random stalls, and a long hold-off counted down here when requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(rx_gaps && $urandom_range(99) < 16);
		end
	end

	// Offer one word, keeping valid high from a previous word when no gap is taken.
	task automatic offer_word(input in_t w, input bit typed, input out_t golden);
		out_t predicted;
		while (tx_gaps && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = positioner_step(w);
		pin_words_due.push_back(typed ? golden : predicted);
	endtask

	// Stop sending and wait until every predicted word has come back.
	task automatic settle_idle();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (pin_words_due.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (pin_words_due.size() != 0) begin
			note_fault("words never returned", pin_words_due.size(), 0);
			pin_words_due.delete();
		end
		repeat (24) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		latch_reg(idx, val[CFG_W-1:0]);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input int unsigned accel, input int unsigned start,
			input int unsigned floor_d, input int unsigned jog);
		write_reg(CFG_ACCEL, accel);
		write_reg(CFG_START, start);
		write_reg(CFG_MIN, floor_d);
		write_reg(CFG_JOG, jog);
	endtask

	// Main sequence: reset, directed table, then random phases over several settings.
	initial begin
		in_t         w;
		int unsigned roll;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_settings(2, 1, 1, 2);
		foreach (opening_rows[i])
			offer_word(opening_rows[i].word, opening_rows[i].typed, opening_rows[i].golden);
		settle_idle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			load_settings(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
				phase_cfg[p][3]);
			// One phase runs with no idling at all; another starts under a long hold-off.
			tx_gaps = (p != 1) && (p != 2);
			rx_gaps = (p != 1);
			if (p == 2)
				hold_left = 400;
			for (int n = 0; n < phase_len[p]; n++) begin
				w.jog_toward_open = 1'($urandom_range(1));
				roll = $urandom_range(99);
				// Mostly ticks while a move runs, mostly commands while idle.
				if (roll < (in_motion ? 80 : 30)) begin
					w.kind = KIND_TICK;
				end else begin
					case ($urandom_range(9))
						0, 1: w.kind = KIND_JOG;
						2, 3: w.kind = KIND_GO_OPEN;
						4, 5: w.kind = KIND_GO_CLOSE;
						6: w.kind = KIND_SAVE_OPEN;
						7: w.kind = KIND_SAVE_CLOSE;
						8: w.kind = KIND_SPARE_A;
						default: w.kind = KIND_SPARE_B;
					endcase
				end
				offer_word(w, 1'b0, NO_GOLDEN);
			end
			settle_idle();
		end

		if (fail_count == 0)
			$display("stepper_trapezoid_positioner verification clean");
		else
			$display("stepper_trapezoid_positioner verification failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("stepper_trapezoid_positioner verification failed");
		$finish;
	end

endmodule

// File: stepper_trapezoid_positioner.f
rtl/core/stp_pkg.sv
rtl/core/stp_div.sv
rtl/core/stp_dp.sv
rtl/core/stp_ctrl.sv
rtl/core/stepper_trapezoid_positioner.sv
dv/tb_stepper_trapezoid_positioner.sv
